// ===== design/assert_macros.svh =====
// assertion helpers used by the checker in cpu16_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge once reset is released
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");

// next-cycle implication checked once reset is released
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");

`endif

// ===== design/cpu16_pkg.sv =====
`default_nettype none

package cpu16_pkg;

    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_MUL = 5'd2;
    localparam logic [4:0] OP_DIV = 5'd3;
    localparam logic [4:0] OP_AND = 5'd4;
    localparam logic [4:0] OP_OR  = 5'd5;
    localparam logic [4:0] OP_XOR = 5'd6;
    localparam logic [4:0] OP_SHL = 5'd7;
    localparam logic [4:0] OP_LDB = 5'd8;
    localparam logic [4:0] OP_LDW = 5'd9;
    localparam logic [4:0] OP_STB = 5'd10;
    localparam logic [4:0] OP_STW = 5'd11;
    localparam logic [4:0] OP_JMP = 5'd12;
    localparam logic [4:0] OP_JZS = 5'd13;
    localparam logic [4:0] OP_JZC = 5'd14;
    localparam logic [4:0] OP_JCS = 5'd15;
    localparam logic [4:0] OP_JCC = 5'd16;
    localparam logic [4:0] OP_JNS = 5'd17;
    localparam logic [4:0] OP_JNC = 5'd18;

    localparam logic [15:0] PC_STEP = 16'd4;

    typedef struct packed {
        logic [4:0]         op;
        logic [4:0]         dest_index;
        logic [4:0]         first_index;
        logic               use_immediate;
        logic signed [15:0] operand_two;
    } t_instr;

    typedef struct packed {
        logic [15:0] value;
        logic        zero_flag;
        logic        neg_flag;
        logic        carry_flag;
        logic [15:0] next_pc;
        logic        div_error;
    } t_result;

    // divider control
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== design/cpu16_div.sv =====
`default_nettype none

// signed restoring divider, one quotient bit per cycle
module cpu16_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cpu16_pkg::t_div_req i_req,
    output cpu16_pkg::t_div_rsp     o_rsp
);
    import cpu16_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_dvs, n_dvs;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [16:0] trial;
    logic [16:0] q_mag;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[15]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 16'd0;
            n_quo  = i_req.dividend[15] ? (16'd0 - i_req.dividend) : i_req.dividend;
            n_dvs  = i_req.divisor[15] ? (16'd0 - i_req.divisor) : i_req.divisor;
            n_neg  = i_req.dividend[15] ^ i_req.divisor[15];
        end else if (r_busy) begin
            if (trial[16]) begin
                n_rem = {r_rem[14:0], r_quo[15]};
                n_quo = {r_quo[14:0], 1'b0};
            end else begin
                n_rem = trial[15:0];
                n_quo = {r_quo[14:0], 1'b1};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    // magnitude can reach 32768 for -32768 / 1
    assign q_mag = {1'b0, r_quo};
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (17'd0 - q_mag) : q_mag;

endmodule

`default_nettype wire

// ===== design/cpu16_execute_unit.sv =====
`default_nettype none

// channel   | ports                      | handshake
// ----------+----------------------------+-------------------------------------
// command   | i_start, i_instr, o_busy   | taken on i_start high with o_busy low
// result    | o_strobe, o_result         | one word per command, held one cycle
//
// each command runs through fetch of operands, execute and write-back, with a memory
// phase for loads and stores and a divider phase for div by a nonzero divisor;
// alu, logic, jump, shift, mul and div by zero take equally long per accepted word;
// byte loads and stores take longer, word loads and stores longer still (one byte
// per cycle through the single memory port); div waits for 16 quotient bits in the divider
// reset clears pc, flags and register valid bits; memory is not cleared
// the receiver cannot stall: o_strobe lasts exactly one cycle
module cpu16_execute_unit #(
    parameter int NUM_REGS  = 32,
    parameter int MEM_BYTES = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire cpu16_pkg::t_instr i_instr,
    output logic                   o_busy,
    output logic                   o_strobe,
    output cpu16_pkg::t_result     o_result
);
    import cpu16_pkg::*;

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD1  = 7'b0000010,
        S_RD2  = 7'b0000100,
        S_EXE  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_MEM  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // register file: one read port used in turn for rn, operand and rd, valid bits for reset
    logic [15:0]         reg_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [RW-1:0]       rd_addr;
    logic                rd_ok;
    logic [15:0]         r_rdata;
    logic                r_rdata_ok;
    logic                reg_we;
    logic [RW-1:0]       reg_waddr;
    logic [15:0]         reg_wdata;

    // byte memory, one port
    logic [7:0]    byte_mem [MEM_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    r_mdata;

    t_instr      r_ins;
    logic [15:0] r_a, r_s, r_d;     // rn, second operand, rd/base
    logic [1:0]  r_phase;
    logic [15:0] r_pc;
    logic        r_z, r_n, r_c;
    t_result     r_res;
    logic        r_strobe;
    logic [7:0]  r_lo;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [15:0] a_val, s_val;
    logic [15:0] eaddr;
    logic [16:0] sum;
    logic [31:0] prod;
    logic [15:0] shres;
    logic        shc;
    logic        take;
    logic        is_wr;
    logic [15:0] wres;
    logic        wz, wn, wc;
    logic [4:0]  rd_sel;

    cpu16_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // read-port address: rn, then operand register, then rd
    always_comb begin
        case (r_state)
            S_IDLE:  rd_sel = i_instr.first_index;
            S_RD1:   rd_sel = r_ins.operand_two[4:0];
            default: rd_sel = r_ins.dest_index;
        endcase
    end
    assign rd_ok   = (r_state == S_RD1) ? ((r_ins.operand_two[15:5] == 11'd0) &&
                     ({11'd0, rd_sel} < 16'(NUM_REGS))) : (32'(rd_sel) < NUM_REGS);
    assign rd_addr = rd_sel[RW-1:0];

    always_ff @(posedge i_clk) begin
        r_rdata    <= reg_mem[rd_addr];
        r_rdata_ok <= rd_ok && r_valid[rd_addr];
        if (reg_we) reg_mem[reg_waddr] <= reg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) byte_mem[mem_addr] <= mem_wdata;
        r_mdata <= byte_mem[mem_addr];
    end

    assign a_val = r_a;
    assign s_val = r_s;
    assign eaddr = (r_ins.op == OP_STB || r_ins.op == OP_STW) ? (r_d + r_s) : (r_a + r_s);
    assign mem_addr = AW'(eaddr + {15'd0, r_phase[0]});
    // byte stores write once, word stores low then high byte
    assign mem_we   = (r_state == S_MEM) &&
                      ((r_ins.op == OP_STB && r_phase == 2'd0) ||
                       (r_ins.op == OP_STW && r_phase != 2'd2));
    assign mem_wdata = r_phase[0] ? r_a[15:8] : r_a[7:0];

    assign sum  = (r_ins.op == OP_SUB) ? ({1'b0, a_val} - {1'b0, s_val})
                                       : ({1'b0, a_val} + {1'b0, s_val});
    assign prod = $signed(a_val) * $signed(s_val);

    // shifter; shift amount is small once clamped
    always_comb begin
        logic [4:0]  amt;
        logic [31:0] wide;
        logic [15:0] neg_s;
        amt   = 5'd0;
        wide  = 32'd0;
        neg_s = 16'd0 - s_val;
        shres = a_val;
        shc   = 1'b0;
        if (s_val == 16'd0) begin
            shres = a_val;
            shc   = 1'b0;
        end else if (!s_val[15]) begin
            amt   = (s_val > 16'd17) ? 5'd17 : s_val[4:0];
            wide  = {16'd0, a_val} << amt;
            shres = wide[15:0];
            shc   = wide[16];
        end else begin
            amt   = (neg_s > 16'd16) ? 5'd16 : neg_s[4:0];
            wide  = $signed({a_val, 16'd0}) >>> amt;
            shres = wide[31:16];
            shc   = wide[15];
        end
    end

    always_comb begin
        case (r_ins.op)
            OP_JMP:  take = 1'b1;
            OP_JZS:  take = r_z;
            OP_JZC:  take = !r_z;
            OP_JCS:  take = r_c;
            OP_JCC:  take = !r_c;
            OP_JNS:  take = r_n;
            OP_JNC:  take = !r_n;
            default: take = 1'b0;
        endcase
    end

    // result of the operations computed combinationally in S_EXE
    always_comb begin
        is_wr = 1'b1;
        wres  = 16'd0;
        wz    = r_z;
        wn    = r_n;
        wc    = 1'b0;
        case (r_ins.op)
            OP_ADD: begin
                wres = sum[15:0]; wz = (sum == 17'd0); wn = sum[15]; wc = sum[16];
            end
            OP_SUB: begin
                wres = sum[15:0]; wz = (sum == 17'd0); wn = sum[15]; wc = sum[16];
            end
            OP_MUL: begin
                wres = prod[15:0]; wz = (prod == 32'd0); wn = prod[31]; wc = prod[15];
            end
            OP_AND: begin
                wres = a_val & s_val; wz = (wres == 16'd0); wn = wres[15];
            end
            OP_OR: begin
                wres = a_val | s_val; wz = (wres == 16'd0); wn = wres[15];
            end
            OP_XOR: begin
                wres = a_val ^ s_val; wz = (wres == 16'd0); wn = wres[15];
            end
            OP_SHL: begin
                wres = shres; wz = (wres == 16'd0); wn = wres[15]; wc = shc;
            end
            default: begin
                is_wr = 1'b0; wc = r_c;
            end
        endcase
    end

    assign div_req.start    = (r_state == S_EXE) && (r_ins.op == OP_DIV) && (r_s != 16'd0);
    assign div_req.dividend = r_a;
    assign div_req.divisor  = r_s;

    always_comb begin
        n_state   = r_state;
        reg_we    = 1'b0;
        reg_waddr = r_ins.dest_index[RW-1:0];
        reg_wdata = wres;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_EXE;
            S_EXE: begin
                if (r_ins.op == OP_DIV) begin
                    n_state = (r_s == 16'd0) ? S_DONE : S_DIV;
                end else if (r_ins.op >= OP_LDB && r_ins.op <= OP_STW) begin
                    n_state = S_MEM;
                end else begin
                    n_state = S_DONE;
                    reg_we  = is_wr;
                end
            end
            S_DIV: if (div_rsp.done) begin
                n_state   = S_DONE;
                reg_we    = 1'b1;
                reg_wdata = {div_rsp.quotient[16], div_rsp.quotient[14:0]};
            end
            S_MEM: begin
                if ((r_ins.op == OP_LDB || r_ins.op == OP_STB) && r_phase == 2'd1) begin
                    n_state = S_DONE;
                    reg_we  = (r_ins.op == OP_LDB);
                    reg_wdata = {{8{r_mdata[7]}}, r_mdata};
                end else if (r_phase == 2'd2) begin
                    n_state = S_DONE;
                    reg_we  = (r_ins.op == OP_LDW);
                    reg_wdata = {r_mdata, r_lo};
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (32'(r_ins.dest_index) >= NUM_REGS) reg_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_pc     <= 16'd0;
            r_z      <= 1'b0;
            r_n      <= 1'b0;
            r_c      <= 1'b0;
            r_strobe <= 1'b0;
            r_phase  <= 2'd0;
        end else begin
            r_state  <= n_state;
            // word shown while in S_DONE
            r_strobe <= (n_state == S_DONE);
            if (reg_we) r_valid[reg_waddr] <= 1'b1;
            if (r_state == S_MEM) r_phase <= r_phase + 2'd1;
            else                  r_phase <= 2'd0;
            case (r_state)
                S_EXE: begin
                    if (r_ins.op == OP_DIV) begin
                        // rd read lands during S_EXE
                        if (r_s == 16'd0) begin
                            r_res <= '{value: (r_rdata_ok ? r_rdata : 16'd0),
                                       zero_flag: r_z, neg_flag: r_n,
                                       carry_flag: r_c, next_pc: r_pc, div_error: 1'b1};
                        end
                    end else if (!(r_ins.op >= OP_LDB && r_ins.op <= OP_STW)) begin
                        if (r_ins.op >= OP_JMP && r_ins.op <= OP_JNC) begin
                            r_pc  <= take ? r_ins.operand_two : (r_pc + PC_STEP);
                            r_res <= '{value: 16'd0, zero_flag: r_z, neg_flag: r_n,
                                       carry_flag: r_c,
                                       next_pc: take ? r_ins.operand_two : (r_pc + PC_STEP),
                                       div_error: 1'b0};
                        end else begin
                            r_z <= wz; r_n <= wn; r_c <= wc;
                            r_res <= '{value: wres, zero_flag: wz, neg_flag: wn,
                                       carry_flag: wc, next_pc: r_pc, div_error: 1'b0};
                        end
                    end
                end
                S_DIV: if (div_rsp.done) begin
                    r_z <= (div_rsp.quotient == 17'd0);
                    r_n <= div_rsp.quotient[16];
                    r_c <= div_rsp.quotient[15];
                    r_res <= '{value: {div_rsp.quotient[16], div_rsp.quotient[14:0]},
                               zero_flag: (div_rsp.quotient == 17'd0),
                               neg_flag: div_rsp.quotient[16],
                               carry_flag: div_rsp.quotient[15],
                               next_pc: r_pc, div_error: 1'b0};
                end
                S_MEM: begin
                    if (r_phase == 2'd1) r_lo <= r_mdata;
                    if (r_ins.op == OP_LDB && r_phase == 2'd1) begin
                        r_z <= (r_mdata == 8'd0); r_n <= r_mdata[7]; r_c <= 1'b0;
                        r_res <= '{value: {{8{r_mdata[7]}}, r_mdata},
                                   zero_flag: (r_mdata == 8'd0), neg_flag: r_mdata[7],
                                   carry_flag: 1'b0, next_pc: r_pc, div_error: 1'b0};
                    end else if (r_ins.op == OP_STB && r_phase == 2'd1) begin
                        r_z <= (r_a[7:0] == 8'd0); r_n <= r_a[7]; r_c <= 1'b0;
                        r_res <= '{value: {8'd0, r_a[7:0]},
                                   zero_flag: (r_a[7:0] == 8'd0), neg_flag: r_a[7],
                                   carry_flag: 1'b0, next_pc: r_pc, div_error: 1'b0};
                    end else if (r_ins.op == OP_LDW && r_phase == 2'd2) begin
                        r_z <= ({r_mdata, r_lo} == 16'd0); r_n <= r_mdata[7]; r_c <= 1'b0;
                        r_res <= '{value: {r_mdata, r_lo},
                                   zero_flag: ({r_mdata, r_lo} == 16'd0),
                                   neg_flag: r_mdata[7],
                                   carry_flag: 1'b0, next_pc: r_pc, div_error: 1'b0};
                    end else if (r_ins.op == OP_STW && r_phase == 2'd2) begin
                        r_z <= (r_a == 16'd0); r_n <= r_a[15]; r_c <= 1'b0;
                        r_res <= '{value: r_a, zero_flag: (r_a == 16'd0), neg_flag: r_a[15],
                                   carry_flag: 1'b0, next_pc: r_pc, div_error: 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    // operand capture; rd lands during S_EXE and stores take it from r_d
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_start) r_ins <= i_instr;
            S_RD1:  r_a <= r_rdata_ok ? r_rdata : 16'd0;
            S_RD2: begin
                r_s <= r_ins.use_immediate ? r_ins.operand_two
                                           : (r_rdata_ok ? r_rdata : 16'd0);
            end
            S_EXE:  r_d <= r_rdata_ok ? r_rdata : 16'd0;
            default: ;
        endcase
    end

    // unknown opcodes report the current state
    assign o_busy   = (r_state != S_IDLE) || r_strobe;
    assign o_strobe = r_strobe;
    always_comb begin
        o_result = r_res;
        if (r_ins.op > OP_JNC) begin
            o_result = '{value: 16'd0, zero_flag: r_z, neg_flag: r_n,
                         carry_flag: r_c, next_pc: r_pc, div_error: 1'b0};
        end
    end

endmodule

`default_nettype wire

// ===== design/cpu16_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// port-level checks of the execute unit
module cpu16_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic              o_strobe,
    input wire cpu16_pkg::t_result o_result
);
    import cpu16_pkg::*;

    // a command starts a run: busy follows acceptance
    `CHK_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // the strobe shows one word and then drops
    `CHK_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    // no word without a command in flight
    `CHK_IMPLY(a_strobe_busy, i_clk, i_rst_n, o_strobe, o_busy)
    // no word in the cycle right after a command is taken
    `CHK_NEXT(a_no_early_word, i_clk, i_rst_n, i_start && !o_busy, !o_strobe)

endmodule

bind cpu16_execute_unit cpu16_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire

// ===== dv/cpu16_execute_unit_checker.sv =====
`default_nettype none

module cpu16_execute_unit_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire cpu16_pkg::t_instr   i_instr,
    input  wire logic                i_strobe,
    input  wire cpu16_pkg::t_result  i_result,
    output int                       o_fail_count,
    output int                       o_pending
);
    import cpu16_pkg::*;

    logic [15:0] regs [0:31];
    logic [7:0]  mem_bytes [0:65535];
    logic [15:0] pc;
    logic        fz, fn, fc;
    t_result     result_q[$];

    assign o_pending = result_q.size();

    // executes one instruction against the shadow machine state
    task automatic execute_instr(input t_instr w, output t_result r);
        logic [15:0] a, s, res, t, base, o2;
        logic [16:0] sum;
        int          sa, ss, p, q, sh;
        logic        derr, take;
        o2   = w.operand_two;
        a    = regs[w.first_index];
        s    = w.use_immediate ? o2 : ((o2 < 16'd32) ? regs[o2[4:0]] : 16'h0000);
        sa   = $signed(a);
        ss   = $signed(s);
        res  = '0;
        derr = 1'b0;
        case (w.op)
            OP_ADD, OP_SUB: begin
                sum = (w.op == OP_ADD) ? ({1'b0, a} + {1'b0, s}) : ({1'b0, a} - {1'b0, s});
                fz = (sum == '0); fn = sum[15]; fc = sum[16];
                res = sum[15:0];
                regs[w.dest_index] = res;
            end
            OP_MUL: begin
                p = sa * ss;
                fz = (p == 0); fn = (p < 0); fc = p[15];
                res = p[15:0];
                regs[w.dest_index] = res;
            end
            OP_DIV: begin
                if (ss == 0) begin
                    derr = 1'b1;
                    res  = regs[w.dest_index];
                end else begin
                    q = sa / ss;
                    fz = (q == 0); fn = (q < 0); fc = q[15];
                    res = {fn, q[14:0]};
                    regs[w.dest_index] = res;
                end
            end
            OP_AND, OP_OR, OP_XOR: begin
                res = (w.op == OP_AND) ? (a & s) : (w.op == OP_OR) ? (a | s) : (a ^ s);
                fz = (res == '0); fn = res[15]; fc = 1'b0;
                regs[w.dest_index] = res;
            end
            OP_SHL: begin
                if (ss == 0) begin
                    res = a; fc = 1'b0;
                end else if (ss > 0) begin
                    sh = ss - 1;
                    t = (sh >= 16) ? 16'h0000 : (a << sh);
                    fc = t[15];
                    res = t << 1;
                end else begin
                    sh = -ss - 1;
                    if (sh > 15) sh = 15;
                    t = $signed(a) >>> sh;
                    fc = t[0];
                    res = $signed(t) >>> 1;
                end
                fz = (res == '0); fn = res[15];
                regs[w.dest_index] = res;
            end
            OP_LDB: begin
                t = a + s;
                res = {{8{mem_bytes[t][7]}}, mem_bytes[t]};
                fz = (res == '0); fn = res[15]; fc = 1'b0;
                regs[w.dest_index] = res;
            end
            OP_LDW: begin
                t = a + s;
                res = {mem_bytes[16'(t + 16'd1)], mem_bytes[t]};
                fz = (res == '0); fn = res[15]; fc = 1'b0;
                regs[w.dest_index] = res;
            end
            OP_STB: begin
                base = regs[w.dest_index];
                t = base + s;
                mem_bytes[t] = a[7:0];
                res = {8'h00, a[7:0]};
                fz = (a[7:0] == '0); fn = a[7]; fc = 1'b0;
            end
            OP_STW: begin
                base = regs[w.dest_index];
                t = base + s;
                mem_bytes[t] = a[7:0];
                mem_bytes[16'(t + 16'd1)] = a[15:8];
                res = a;
                fz = (a == '0); fn = a[15]; fc = 1'b0;
            end
            OP_JMP, OP_JZS, OP_JZC, OP_JCS, OP_JCC, OP_JNS, OP_JNC: begin
                case (w.op)
                    OP_JMP:  take = 1'b1;
                    OP_JZS:  take = fz;
                    OP_JZC:  take = !fz;
                    OP_JCS:  take = fc;
                    OP_JCC:  take = !fc;
                    OP_JNS:  take = fn;
                    default: take = !fn;
                endcase
                pc = take ? o2 : (pc + PC_STEP);
            end
            default: ;
        endcase
        r.value      = res;
        r.zero_flag  = fz;
        r.neg_flag   = fn;
        r.carry_flag = fc;
        r.next_pc    = pc;
        r.div_error  = derr;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (regs[k]) regs[k] = '0;
            pc = '0; fz = 1'b0; fn = 1'b0; fc = 1'b0;
            result_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_strobe) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: %p", $time, i_result);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (want.value !== i_result.value) begin
                        $display("%0t: value exp %h got %h", $time, want.value, i_result.value);
                        o_fail_count++;
                    end
                    if (want.zero_flag !== i_result.zero_flag) begin
                        $display("%0t: zero_flag exp %b got %b", $time,
                                 want.zero_flag, i_result.zero_flag);
                        o_fail_count++;
                    end
                    if (want.neg_flag !== i_result.neg_flag) begin
                        $display("%0t: neg_flag exp %b got %b", $time,
                                 want.neg_flag, i_result.neg_flag);
                        o_fail_count++;
                    end
                    if (want.carry_flag !== i_result.carry_flag) begin
                        $display("%0t: carry_flag exp %b got %b", $time,
                                 want.carry_flag, i_result.carry_flag);
                        o_fail_count++;
                    end
                    if (want.next_pc !== i_result.next_pc) begin
                        $display("%0t: next_pc exp %h got %h", $time,
                                 want.next_pc, i_result.next_pc);
                        o_fail_count++;
                    end
                    if (want.div_error !== i_result.div_error) begin
                        $display("%0t: div_error exp %b got %b", $time,
                                 want.div_error, i_result.div_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                execute_instr(i_instr, want);
                result_q.push_back(want);
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/cpu16_execute_unit_tb.sv =====
`default_nettype none

module cpu16_execute_unit_tb;
    import cpu16_pkg::*;

    // cycles without any accepted word or result word before the run is declared hung
    localparam int HANG_LIMIT = 1000;
    localparam int RANDOM_WORDS = 1050;
    // the last stretch of the run goes without idle cycles
    localparam int QUIET_TAIL = 150;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_start;
    t_instr   i_instr;
    logic     o_busy;
    logic     o_strobe;
    t_result  o_result;
    int       fail_count;
    int       pending;
    int       idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cpu16_execute_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_instr  (i_instr),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    cpu16_execute_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_instr      (i_instr),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: any accepted command or result word resets the count
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_instr mk(logic [4:0] op, logic [4:0] rd, logic [4:0] rn,
                                  logic imm, logic [15:0] o2);
        t_instr w;
        w.op            = op;
        w.dest_index    = rd;
        w.first_index   = rn;
        w.use_immediate = imm;
        w.operand_two   = o2;
        return w;
    endfunction

    // holds start high until the word is taken; start stays up for a following word
    task automatic issue_word(input t_instr w);
        i_start <= 1'b1;
        i_instr <= w;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_burst(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // second operand: immediates when imm is set, else mostly register indexes in range, sometimes out of range
    function automatic logic [15:0] pick_operand(logic imm);
        if (imm) begin
            case ($urandom_range(0, 3))
                0:       return 16'($signed($urandom_range(0, 40)) - 20);
                1:       return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF;
                default: return 16'($urandom());
            endcase
        end
        return ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 31));
    endfunction

    initial begin
        logic [4:0] op, base;
        logic       imm;
        logic [15:0] o2;
        int         sent;
        logic       mid_drained;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_instr     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation and the corner cases
        issue_word(mk(OP_ADD, 5'd1, 5'd0, 1'b1, 16'h7FFF));
        issue_word(mk(OP_ADD, 5'd2, 5'd1, 1'b1, 16'h0001));   // r2 = 0x8000
        issue_word(mk(OP_ADD, 5'd3, 5'd2, 1'b1, 16'h8000));   // carry out, 17-bit sum nonzero
        issue_word(mk(OP_SUB, 5'd4, 5'd1, 1'b0, 16'd1));      // equal operands
        issue_word(mk(OP_SUB, 5'd4, 5'd0, 1'b1, 16'h0001));   // borrow
        issue_word(mk(OP_MUL, 5'd5, 5'd2, 1'b1, 16'hFFFF));
        issue_word(mk(OP_DIV, 5'd6, 5'd1, 1'b1, 16'h0000));   // divide by zero
        issue_word(mk(OP_DIV, 5'd6, 5'd2, 1'b1, 16'hFFFF));   // most negative by minus one
        issue_word(mk(OP_DIV, 5'd7, 5'd1, 1'b0, 16'd2));
        issue_word(mk(OP_AND, 5'd8, 5'd2, 1'b1, 16'hFFFF));
        issue_word(mk(OP_OR,  5'd8, 5'd0, 1'b1, 16'h0000));
        issue_word(mk(OP_XOR, 5'd9, 5'd1, 1'b1, 16'hFFFF));
        issue_word(mk(OP_SHL, 5'd10, 5'd1, 1'b1, 16'h0000));  // shift by zero
        issue_word(mk(OP_SHL, 5'd10, 5'd1, 1'b1, 16'd17));    // very long left shift
        issue_word(mk(OP_SHL, 5'd10, 5'd2, 1'b1, 16'hFFF0));  // right by sixteen
        issue_word(mk(OP_SHL, 5'd10, 5'd1, 1'b1, 16'hFFFF));
        issue_word(mk(OP_STW, 5'd0, 5'd2, 1'b1, 16'hFFFF));   // word access wraps
        issue_word(mk(OP_LDW, 5'd11, 5'd0, 1'b1, 16'hFFFF));
        issue_word(mk(OP_STB, 5'd0, 5'd9, 1'b1, 16'h000A));
        issue_word(mk(OP_LDB, 5'd12, 5'd0, 1'b1, 16'h000A));
        issue_word(mk(OP_ADD, 5'd13, 5'd1, 1'b0, 16'd100));   // index out of range
        for (int k = OP_JMP; k <= OP_JNC; k++)
            issue_word(mk(5'(k), 5'd0, 5'd0, 1'b0, 16'($urandom())));
        issue_word(mk(5'd31, 5'd31, 5'd31, 1'b1, 16'hFFFF));  // unused opcode
        drain_results();

        sent = 0;
        mid_drained = 1'b0;
        while (sent < RANDOM_WORDS) begin
            if (!mid_drained && sent >= RANDOM_WORDS / 3) begin
                drain_results();
                mid_drained = 1'b1;
            end
            if (sent < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 4) == 0)
                idle_burst($urandom_range(1, 6));
            imm = 1'($urandom());
            o2  = pick_operand(imm);
            if ($urandom_range(0, 3) == 0) begin
                // store then load back through the same base and offset
                base = 5'($urandom());
                op   = $urandom_range(0, 1) ? OP_STW : OP_STB;
                issue_word(mk(op, base, 5'($urandom()), imm, o2));
                if (sent < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                    idle_burst($urandom_range(1, 6));
                op = (op == OP_STW && $urandom_range(0, 2) != 0) ? OP_LDW : OP_LDB;
                issue_word(mk(op, 5'($urandom()), base, imm, o2));
                sent += 2;
            end else begin
                op = 5'($urandom());
                if (op == OP_LDB || op == OP_LDW)
                    op = op + 5'd2;   // loads only follow a matching store
                issue_word(mk(op, 5'($urandom()), 5'($urandom()), imm, o2));
                sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
